FILE: hw/rtl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants of the script line cleaner.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned SP_W         = 13;
  localparam int unsigned LEN_W        = 14;
  localparam int unsigned MAX_LINE_DEF = 8192;

  localparam logic [SP_W-1:0] PEND_MAX = {SP_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EOL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOF  = 2'd2;

  // result slots of one byte, in output order
  localparam int unsigned SLOT_CHAR = 0;
  localparam int unsigned SLOT_EOL  = 1;
  localparam int unsigned SLOT_EOF  = 2;
  localparam int unsigned NSLOT     = 3;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } slc_item_t;

  typedef struct packed {
    logic [NSLOT-1:0]  mask;
    logic [DATA_W-1:0] char_out;
    logic [SP_W-1:0]   spaces_before;
    logic [LEN_W-1:0]  raw_length;
  } slc_res_t;

endpackage

FILE: hw/rtl/slc_in_if.sv
// ----------------------------------------------------------------------------
// slc_in_if
// Byte channel into the script line cleaner.
// ----------------------------------------------------------------------------
interface slc_in_if;
  logic                      valid;
  logic                      ready;
  logic [slc_pkg::DATA_W-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/slc_out_if.sv
// ----------------------------------------------------------------------------
// slc_out_if
// Result channel out of the script line cleaner.
// ----------------------------------------------------------------------------
interface slc_out_if;
  logic                       valid;
  logic                       ready;
  logic [slc_pkg::KIND_W-1:0] kind;
  logic [slc_pkg::DATA_W-1:0] char_out;
  logic [slc_pkg::SP_W-1:0]   spaces_before;
  logic [slc_pkg::LEN_W-1:0]  raw_length;
  logic                       run_last;

  modport source (output valid, output kind, output char_out, output spaces_before,
                  output raw_length, output run_last, input ready);
  modport sink   (input valid, input kind, input char_out, input spaces_before,
                  input raw_length, input run_last, output ready);
endinterface

FILE: hw/rtl/slc_in_reg.sv
// ----------------------------------------------------------------------------
// slc_in_reg
// Input register: holds one byte beat until the core takes it.
// ----------------------------------------------------------------------------
module slc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  slc_in_if.sink             in_i,
  input  logic               take_i,
  output logic               valid_o,
  output slc_pkg::slc_item_t item_o
);

  logic               valid_q, valid_d;
  slc_pkg::slc_item_t item_q;
  logic               fire;

  assign in_i.ready = !valid_q || take_i;
  assign fire       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.last_byte <= in_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/slc_core.sv
// ----------------------------------------------------------------------------
// slc_core
// Line state and per-byte cleaning logic; yields up to three results a byte.
// ----------------------------------------------------------------------------
module slc_core #(
  parameter int unsigned MAX_LINE = slc_pkg::MAX_LINE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  slc_pkg::slc_item_t item_i,
  output slc_pkg::slc_res_t  res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LINE + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LINE);

  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_COMMENT = 2'd1;
  localparam logic [1:0] MODE_LINE    = 2'd2;
  localparam logic [1:0] MODE_CUT     = 2'd3;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_NUL   = 8'd0;

  logic [1:0]              mode_q, mode_d;
  logic                    quote_q, quote_d;
  logic                    pws_q, pws_d;
  logic [slc_pkg::SP_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  logic [7:0]              b, c;
  logic                    eol;
  logic [CNT_W+slc_pkg::LEN_W-1:0] cnt_ext;

  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    pws_d   = pws_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    res_o   = '0;
    b       = item_i.data_byte;
    eol     = (b == CH_CR) || (b == CH_LF);
    c       = (b == CH_TAB) ? CH_SPACE : b;
    cnt_ext = '0;

    if (mode_d == MODE_START) begin
      if (eol || b == CH_SPACE || b == CH_TAB) begin
        mode_d = MODE_START;
      end else if (b == CH_SEMI) begin
        mode_d = MODE_COMMENT;
      end else begin
        mode_d  = MODE_LINE;
        quote_d = 1'b0;
        pws_d   = 1'b1;
        pend_d  = '0;
        cnt_d   = '0;
      end
    end else if (mode_d == MODE_COMMENT) begin
      if (eol) begin
        mode_d = MODE_START;
      end
    end

    if (mode_d == MODE_LINE || mode_d == MODE_CUT) begin
      if (eol) begin
        cnt_ext = {{slc_pkg::LEN_W{1'b0}}, cnt_d};
        res_o.mask[slc_pkg::SLOT_EOL] = 1'b1;
        res_o.raw_length = cnt_ext[slc_pkg::LEN_W-1:0];
        mode_d = MODE_START;
      end else begin
        if (cnt_d < CNT_MAX) begin
          cnt_d = cnt_d + CNT_W'(1);
        end
        if (mode_d == MODE_LINE) begin
          if (c == CH_QUOTE) begin
            quote_d = !quote_d;
          end
          if (c == CH_NUL || (c == CH_SEMI && !quote_d)) begin
            mode_d = MODE_CUT;
          end else if (c == CH_SPACE) begin
            if ((quote_d || !pws_d) && pend_d < slc_pkg::PEND_MAX) begin
              pend_d = pend_d + slc_pkg::SP_W'(1);
            end
            pws_d = 1'b1;
          end else begin
            res_o.mask[slc_pkg::SLOT_CHAR] = 1'b1;
            res_o.char_out      = c;
            res_o.spaces_before = pend_d;
            pend_d = '0;
            pws_d  = 1'b0;
          end
        end
      end
    end

    if (item_i.last_byte) begin
      if (mode_d == MODE_LINE || mode_d == MODE_CUT) begin
        cnt_ext = {{slc_pkg::LEN_W{1'b0}}, cnt_d};
        res_o.mask[slc_pkg::SLOT_EOL] = 1'b1;
        res_o.raw_length = cnt_ext[slc_pkg::LEN_W-1:0];
      end
      res_o.mask[slc_pkg::SLOT_EOF] = 1'b1;
      mode_d  = MODE_START;
      quote_d = 1'b0;
      pws_d   = 1'b1;
      pend_d  = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_START;
      quote_q <= 1'b0;
      pws_q   <= 1'b1;
      pend_q  <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      pws_q   <= pws_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/slc_out_buf.sv
// ----------------------------------------------------------------------------
// slc_out_buf
// Result register: holds the results of one byte and sends them one beat each.
// ----------------------------------------------------------------------------
module slc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  slc_pkg::slc_res_t res_i,
  output logic              take_o,
  slc_out_if.source         out_o
);

  logic [slc_pkg::NSLOT-1:0] mask_q, mask_d, rest;
  slc_pkg::slc_res_t         res_q;
  logic                      fire;

  assign rest   = mask_q & (mask_q - slc_pkg::NSLOT'(1));
  assign fire   = out_o.valid && out_o.ready;
  assign take_o = (mask_q == '0) || (fire && rest == '0);

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = res_i.mask;
    end else if (fire) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  always_comb begin
    out_o.valid         = (mask_q != '0);
    out_o.run_last      = (rest == '0);
    out_o.char_out      = '0;
    out_o.spaces_before = '0;
    out_o.raw_length    = '0;
    if (mask_q[slc_pkg::SLOT_CHAR]) begin
      out_o.kind          = slc_pkg::KIND_CHAR;
      out_o.char_out      = res_q.char_out;
      out_o.spaces_before = res_q.spaces_before;
    end else if (mask_q[slc_pkg::SLOT_EOL]) begin
      out_o.kind       = slc_pkg::KIND_EOL;
      out_o.raw_length = res_q.raw_length;
    end else begin
      out_o.kind = slc_pkg::KIND_EOF;
    end
  end

endmodule

FILE: hw/rtl/script_line_cleaner.sv
// ----------------------------------------------------------------------------
// script_line_cleaner
// Streams a script file byte by byte and emits cleaned lines.
// ----------------------------------------------------------------------------
// A byte passes an input register, then the combinational cleaning logic
// that updates the line state and loads the results it causes into the
// result register. Bytes that cause no result or one result flow at one byte
// per cycle while the output port takes each result; a byte causing k results
// (a character, end of line and end of file on the final byte) holds the
// result register until all k are sent, since the output port sends one
// result per beat. MAX_LINE (16 to 65536) sets the saturation of the raw line
// length counter; raw_length carries its low 14 bits.
module script_line_cleaner #(
  parameter int unsigned MAX_LINE = slc_pkg::MAX_LINE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slc_in_if.sink    in_i,
  slc_out_if.source out_o
);

  logic               take;
  logic               item_valid;
  logic               step;
  slc_pkg::slc_item_t item;
  slc_pkg::slc_res_t  res;

  assign step = item_valid && take;

  slc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  slc_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .res_o  (res)
  );

  slc_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .res_i  (res),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule
